// ===== hdl/vpet_pkg.sv =====
// Shared types, constants and helpers for the paraboloid environment texgen core.
// Depends on nothing; every other file in the block imports it.
package vpet_pkg;

   // Configuration register indexes, in port order.
   typedef enum logic [2:0] {
      CSR_ROT_ROW0 = 3'd0,
      CSR_ROT_ROW1 = 3'd1,
      CSR_ROT_ROW2 = 3'd2,
      CSR_EYE_X    = 3'd3,
      CSR_EYE_Y    = 3'd4,
      CSR_EYE_Z    = 3'd5
   } csr_index_type;

   // Field widths.
   localparam int POS_W   = 24;
   localparam int NRM_W   = 16;
   localparam int ROW_W   = 48;
   localparam int REFL_W  = 16;
   localparam int TEX_W   = 16;
   localparam int COLOR_W = 32;

   // Block scaling keeps magnitudes below two to the thirtieth.
   localparam int MAG_W = 30;

   // Reset values of the matrix rows.
   localparam logic [ROW_W-1:0] ROT_ROW0_RST = 48'h0000_4000_0000;
   localparam logic [ROW_W-1:0] ROT_ROW1_RST = 48'h0000_1000_0000;
   localparam logic [ROW_W-1:0] ROT_ROW2_RST = 48'h0000_0000_4000;

   // Per-side vertex colors, RGBA with red in the top byte.
   localparam logic [7:0] CH_HALF = 8'h80;
   localparam logic [7:0] CH_FULL = 8'hff;
   localparam logic [7:0] CH_BACK_A  = 8'h7f;
   localparam logic [7:0] CH_FRONT_A = 8'hbc;
   localparam logic [COLOR_W-1:0] COLOR_BACK  = {CH_HALF, CH_FULL, CH_HALF, CH_BACK_A};
   localparam logic [COLOR_W-1:0] COLOR_FRONT = {CH_HALF, CH_HALF, CH_FULL, CH_FRONT_A};

   // Texture center and paraboloid offset.
   localparam logic [16:0] TEX_HALF = 17'd32768;
   localparam logic [15:0] ONE_Q14  = 16'd16384;

   // Right shift that brings the largest magnitude (msb of the OR of all
   // magnitudes) below two to the thirtieth.
   function automatic logic [5:0] scale_shift(input logic [61:0] m);
      logic [5:0] s;
      s = '0;
      for (int i = MAG_W; i < 62; i++) begin
         if (m[i]) begin
            s = 6'(i - (MAG_W - 1));
         end
      end
      return s;
   endfunction

endpackage

// ===== hdl/vpet_reflect.sv =====
// Front end: view vector, reflection about the normal and block scaling.
// Eight register stages; uses vpet_pkg.
module vpet_reflect
   import vpet_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [POS_W-1:0] pos_x,
   input  logic signed [POS_W-1:0] pos_y,
   input  logic signed [POS_W-1:0] pos_z,
   input  logic signed [NRM_W-1:0] norm_x,
   input  logic signed [NRM_W-1:0] norm_y,
   input  logic signed [NRM_W-1:0] norm_z,
   input  logic                    last_in,
   input  logic signed [POS_W-1:0] eye_x,
   input  logic signed [POS_W-1:0] eye_y,
   input  logic signed [POS_W-1:0] eye_z,
   output logic                    out_valid,
   output logic signed [MAG_W:0]   r_out [3],
   output logic                    last_out
);

   logic [7:0] valid_ff;
   logic [7:0] last_ff;

   // Stage 1: view vector.
   logic signed [24:0] s1_d_in [3];
   logic signed [24:0] s1_d_ff [3];
   logic signed [15:0] s1_n_ff [3];
   // Stage 2: products.
   logic signed [40:0] s2_pd_in [3];
   logic signed [40:0] s2_pd_ff [3];
   logic signed [32:0] s2_nsq_in [3];
   logic [31:0]        s2_nsq_ff [3];
   logic signed [24:0] s2_d_ff [3];
   logic signed [15:0] s2_n_ff [3];
   // Stage 3: dot products.
   logic signed [42:0] s3_nd_ff;
   logic [31:0]        s3_nn_ff;
   logic signed [24:0] s3_d_ff [3];
   logic signed [15:0] s3_n_ff [3];
   // Stage 4: scaled terms.
   logic signed [58:0] s4_a_ff [3];
   logic signed [57:0] s4_b_ff [3];
   // Stage 5: reflection.
   logic signed [59:0] s5_r_ff [3];
   // Stage 6: sign and magnitude.
   logic [58:0] s6_mag_in [3];
   logic [58:0] s6_mag_ff [3];
   logic [2:0]  s6_sgn_ff;
   // Stage 7: scale shift.
   logic [5:0]  s7_sh_in;
   logic [5:0]  s7_sh_ff;
   logic [58:0] s7_mag_ff [3];
   logic [2:0]  s7_sgn_ff;
   // Stage 8: scaled signed vector.
   logic signed [MAG_W:0] s8_r_in [3];
   logic signed [MAG_W:0] s8_r_ff [3];

   // Valid and last travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[6:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last_ff <= {last_ff[6:0], last_in};
      end
   end

   // Datapath next values.
   always_comb begin
      logic [58:0] or_mag;
      logic [58:0] shifted;
      s1_d_in[0] = 25'(eye_x) - 25'(pos_x);
      s1_d_in[1] = 25'(eye_y) - 25'(pos_y);
      s1_d_in[2] = 25'(eye_z) - 25'(pos_z);
      for (int i = 0; i < 3; i++) begin
         s2_pd_in[i]  = 41'(s1_n_ff[i]) * 41'(s1_d_ff[i]);
         s2_nsq_in[i] = 33'(s1_n_ff[i]) * 33'(s1_n_ff[i]);
         s6_mag_in[i] = s5_r_ff[i][59] ? 59'(-s5_r_ff[i]) : 59'(s5_r_ff[i]);
      end
      or_mag   = s6_mag_ff[0] | s6_mag_ff[1] | s6_mag_ff[2];
      s7_sh_in = scale_shift(62'(or_mag));
      for (int i = 0; i < 3; i++) begin
         shifted    = s7_mag_ff[i] >> s7_sh_ff;
         s8_r_in[i] = s7_sgn_ff[i] ? -$signed({1'b0, shifted[MAG_W-1:0]})
                                   : $signed({1'b0, shifted[MAG_W-1:0]});
      end
   end

   // Pipeline registers.
   always_ff @(posedge clock) begin
      if (en) begin
         s1_n_ff[0] <= norm_x;
         s1_n_ff[1] <= norm_y;
         s1_n_ff[2] <= norm_z;
         for (int i = 0; i < 3; i++) begin
            s1_d_ff[i]   <= s1_d_in[i];
            s2_pd_ff[i]  <= s2_pd_in[i];
            s2_nsq_ff[i] <= s2_nsq_in[i][31:0];
            s2_d_ff[i]   <= s1_d_ff[i];
            s2_n_ff[i]   <= s1_n_ff[i];
            s3_d_ff[i]   <= s2_d_ff[i];
            s3_n_ff[i]   <= s2_n_ff[i];
            s4_a_ff[i]   <= 59'(s3_nd_ff) * 59'(s3_n_ff[i]);
            s4_b_ff[i]   <= 58'($signed({1'b0, s3_nn_ff})) * 58'(s3_d_ff[i]);
            s5_r_ff[i]   <= (60'(s4_a_ff[i]) <<< 1) - 60'(s4_b_ff[i]);
            s6_mag_ff[i] <= s6_mag_in[i];
            s6_sgn_ff[i] <= s5_r_ff[i][59];
            s7_mag_ff[i] <= s6_mag_ff[i];
            s8_r_ff[i]   <= s8_r_in[i];
         end
         s3_nd_ff  <= 43'(s2_pd_ff[0]) + 43'(s2_pd_ff[1]) + 43'(s2_pd_ff[2]);
         s3_nn_ff  <= s2_nsq_ff[0] + s2_nsq_ff[1] + s2_nsq_ff[2];
         s7_sh_ff  <= s7_sh_in;
         s7_sgn_ff <= s6_sgn_ff;
      end
   end

   assign out_valid = valid_ff[7];
   assign last_out  = last_ff[7];
   assign r_out     = s8_r_ff;

endmodule

// ===== hdl/vpet_rotate.sv =====
// Rotation by the configured matrix, block scaling and sum of squares.
// Seven register stages; uses vpet_pkg.
module vpet_rotate
   import vpet_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic signed [MAG_W:0] r_in [3],
   input  logic                  last_in,
   input  logic [ROW_W-1:0]      rot_row0,
   input  logic [ROW_W-1:0]      rot_row1,
   input  logic [ROW_W-1:0]      rot_row2,
   output logic                  out_valid,
   output logic [61:0]           ss_out,
   output logic [MAG_W-1:0]      wabs_out [3],
   output logic [2:0]            sgn_out,
   output logic                  last_out
);

   logic [6:0] valid_ff;
   logic [6:0] last_ff;

   logic [ROW_W-1:0]    rows [3];
   logic signed [46:0]  s9_p_in  [3][3];
   logic signed [46:0]  s9_p_ff  [3][3];
   logic signed [48:0]  s10_w_ff [3];
   logic [47:0]         s11_mag_in [3];
   logic [47:0]         s11_mag_ff [3];
   logic [2:0]          s11_sgn_ff;
   logic [5:0]          s12_sh_in;
   logic [5:0]          s12_sh_ff;
   logic [47:0]         s12_mag_ff [3];
   logic [2:0]          s12_sgn_ff;
   logic [MAG_W-1:0]    s13_wabs_in [3];
   logic [MAG_W-1:0]    s13_wabs_ff [3];
   logic [2:0]          s13_sgn_ff;
   logic [59:0]         s14_sq_ff [3];
   logic [MAG_W-1:0]    s14_wabs_ff [3];
   logic [2:0]          s14_sgn_ff;
   logic [61:0]         s15_ss_ff;
   logic [MAG_W-1:0]    s15_wabs_ff [3];
   logic [2:0]          s15_sgn_ff;

   assign rows[0] = rot_row0;
   assign rows[1] = rot_row1;
   assign rows[2] = rot_row2;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last_ff <= {last_ff[5:0], last_in};
      end
   end

   // Products, magnitudes, scale shift and scaled magnitudes.
   always_comb begin
      logic [47:0] or_mag;
      logic [47:0] shifted;
      for (int i = 0; i < 3; i++) begin
         for (int c = 0; c < 3; c++) begin
            s9_p_in[i][c] = 47'($signed(rows[i][c*16 +: 16])) * 47'(r_in[c]);
         end
         s11_mag_in[i] = s10_w_ff[i][48] ? 48'(-s10_w_ff[i]) : 48'(s10_w_ff[i]);
      end
      or_mag    = s11_mag_ff[0] | s11_mag_ff[1] | s11_mag_ff[2];
      s12_sh_in = scale_shift(62'(or_mag));
      for (int i = 0; i < 3; i++) begin
         shifted        = s12_mag_ff[i] >> s12_sh_ff;
         s13_wabs_in[i] = shifted[MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
               s9_p_ff[i][c] <= s9_p_in[i][c];
            end
            s10_w_ff[i]    <= 49'(s9_p_ff[i][0]) + 49'(s9_p_ff[i][1]) + 49'(s9_p_ff[i][2]);
            s11_mag_ff[i]  <= s11_mag_in[i];
            s11_sgn_ff[i]  <= s10_w_ff[i][48];
            s12_mag_ff[i]  <= s11_mag_ff[i];
            s13_wabs_ff[i] <= s13_wabs_in[i];
            s14_sq_ff[i]   <= 60'(s13_wabs_ff[i]) * 60'(s13_wabs_ff[i]);
            s14_wabs_ff[i] <= s13_wabs_ff[i];
            s15_wabs_ff[i] <= s14_wabs_ff[i];
         end
         s12_sh_ff  <= s12_sh_in;
         s12_sgn_ff <= s11_sgn_ff;
         s13_sgn_ff <= s12_sgn_ff;
         s14_sgn_ff <= s13_sgn_ff;
         s15_sgn_ff <= s14_sgn_ff;
         s15_ss_ff  <= 62'(s14_sq_ff[0]) + 62'(s14_sq_ff[1]) + 62'(s14_sq_ff[2]);
      end
   end

   assign out_valid = valid_ff[6];
   assign last_out  = last_ff[6];
   assign ss_out    = s15_ss_ff;
   assign wabs_out  = s15_wabs_ff;
   assign sgn_out   = s15_sgn_ff;

endmodule

// ===== hdl/vpet_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a sideband bus.
// Thirty-two register stages; uses vpet_pkg.
module vpet_isqrt
   import vpet_pkg::*;
#(
   parameter int SIDE_W = 94
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [61:0]       radicand,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [31:0]       root,
   output logic [SIDE_W-1:0] side_out
);

   localparam int ST = 32;

   logic [63:0]       v_ff    [ST];
   logic [63:0]       r_ff    [ST];
   logic [SIDE_W-1:0] side_ff [ST];
   logic [ST-1:0]     valid_ff;

   for (genvar k = 0; k < ST; k++) begin : g_stage
      localparam logic [63:0] BIT_C = 64'd1 << (62 - 2 * k);
      logic [63:0]       cur_v;
      logic [63:0]       cur_r;
      logic [SIDE_W-1:0] cur_side;
      logic              cur_valid;
      logic [63:0]       trial;
      logic [63:0]       v_in;
      logic [63:0]       r_in;

      if (k == 0) begin : g_first
         assign cur_v     = 64'(radicand);
         assign cur_r     = '0;
         assign cur_side  = side_in;
         assign cur_valid = in_valid;
      end else begin : g_next
         assign cur_v     = v_ff[k-1];
         assign cur_r     = r_ff[k-1];
         assign cur_side  = side_ff[k-1];
         assign cur_valid = valid_ff[k-1];
      end

      // One digit-by-digit root step.
      always_comb begin
         trial = cur_r + BIT_C;
         if (cur_v >= trial) begin
            v_in = cur_v - trial;
            r_in = (cur_r >> 1) + BIT_C;
         end else begin
            v_in = cur_v;
            r_in = cur_r >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[k]    <= v_in;
            r_ff[k]    <= r_in;
            side_ff[k] <= cur_side;
         end
      end
   end

   assign out_valid = valid_ff[ST-1];
   assign root      = r_ff[ST-1][31:0];
   assign side_out  = side_ff[ST-1];

endmodule

// ===== hdl/vpet_div.sv =====
// Pipelined restoring divider over several lanes, one quotient bit per stage.
// Q_W register stages; uses vpet_pkg.
module vpet_div
   import vpet_pkg::*;
#(
   parameter int LANES  = 3,
   parameter int NUM_W  = 46,
   parameter int DEN_W  = 33,
   parameter int Q_W    = 15,
   parameter int SIDE_W = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [LANES-1:0][NUM_W-1:0]      num,
   input  logic [LANES-1:0][DEN_W-1:0]      den,
   input  logic [SIDE_W-1:0]                side_in,
   output logic                             out_valid,
   output logic [LANES-1:0][Q_W-1:0]        quo,
   output logic [SIDE_W-1:0]                side_out
);

   localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic [LANES-1:0][NUM_W-1:0] rem_ff  [Q_W];
   logic [LANES-1:0][DEN_W-1:0] den_ff  [Q_W];
   logic [LANES-1:0][Q_W-1:0]   quo_ff  [Q_W];
   logic [SIDE_W-1:0]           side_ff [Q_W];
   logic [Q_W-1:0]              valid_ff;

   for (genvar j = 0; j < Q_W; j++) begin : g_stage
      localparam int B = Q_W - 1 - j;
      logic [LANES-1:0][NUM_W-1:0] cur_rem;
      logic [LANES-1:0][DEN_W-1:0] cur_den;
      logic [LANES-1:0][Q_W-1:0]   cur_quo;
      logic [SIDE_W-1:0]           cur_side;
      logic                        cur_valid;
      logic [LANES-1:0][NUM_W-1:0] rem_in;
      logic [LANES-1:0][Q_W-1:0]   quo_in;

      if (j == 0) begin : g_first
         assign cur_rem   = num;
         assign cur_den   = den;
         assign cur_quo   = '0;
         assign cur_side  = side_in;
         assign cur_valid = in_valid;
      end else begin : g_next
         assign cur_rem   = rem_ff[j-1];
         assign cur_den   = den_ff[j-1];
         assign cur_quo   = quo_ff[j-1];
         assign cur_side  = side_ff[j-1];
         assign cur_valid = valid_ff[j-1];
      end

      // Trial subtraction of the shifted divisor in every lane.
      always_comb begin
         logic [W-1:0] trial;
         logic [W-1:0] rem_w;
         for (int l = 0; l < LANES; l++) begin
            trial     = W'(cur_den[l]) << B;
            rem_w     = W'(cur_rem[l]);
            rem_in[l] = cur_rem[l];
            quo_in[l] = cur_quo[l];
            if (rem_w >= trial) begin
               rem_in[l]    = NUM_W'(rem_w - trial);
               quo_in[l][B] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            den_ff[j]  <= cur_den;
            quo_ff[j]  <= quo_in;
            side_ff[j] <= cur_side;
         end
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign quo       = quo_ff[Q_W-1];
   assign side_out  = side_ff[Q_W-1];

endmodule

// ===== hdl/vertex_paraboloid_env_texgen_core.sv =====
// Dual-paraboloid environment texgen core: top level with configuration and output stage.
// Depends on vpet_pkg, vpet_reflect, vpet_rotate, vpet_isqrt and vpet_div.

// The core takes one vertex (position and normal) per clock unless the output stalls, and
// returns one transaction per vertex, in order. The pipeline holds 8 stages of reflection
// and block scaling, 7 of rotation and sum of squares, 32 of square root (one root bit per
// stage), one setup stage, 15 stages of normalizing division, one setup stage, 16 stages
// of texture division and the output register. A stall on the result side freezes the
// whole pipeline and is passed straight back to the request side. Configuration
// registers are written through the csr port; the user must do so only while the
// pipeline is empty, as the block itself does not enforce it.
module vertex_paraboloid_env_texgen_core
   import vpet_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [POS_W-1:0]  req_pos_z,
   input  logic signed [NRM_W-1:0]  req_norm_x,
   input  logic signed [NRM_W-1:0]  req_norm_y,
   input  logic signed [NRM_W-1:0]  req_norm_z,
   input  logic                     req_last_vertex,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [REFL_W-1:0] rsp_refl_x,
   output logic signed [REFL_W-1:0] rsp_refl_y,
   output logic signed [REFL_W-1:0] rsp_refl_z,
   output logic [TEX_W-1:0]         rsp_tex_u,
   output logic [TEX_W-1:0]         rsp_tex_v,
   output logic                     rsp_back_side,
   output logic [COLOR_W-1:0]       rsp_vertex_color,
   output logic                     rsp_last_out,
   input  logic                     csr_wr_en,
   input  logic [2:0]               csr_index,
   input  logic [ROW_W-1:0]         csr_wdata
);

   localparam int SQ_SIDE_W = 3 * MAG_W + 4;
   localparam int NA_SIDE_W = 5;
   localparam int NB_SIDE_W = 3 * 15 + 4;

   logic en;

   logic [ROW_W-1:0]        rot_row0_ff, rot_row1_ff, rot_row2_ff;
   logic signed [POS_W-1:0] eye_x_ff, eye_y_ff, eye_z_ff;

   logic                  rf_valid;
   logic signed [MAG_W:0] rf_r [3];
   logic                  rf_last;

   logic             rt_valid;
   logic [61:0]      rt_ss;
   logic [MAG_W-1:0] rt_wabs [3];
   logic [2:0]       rt_sgn;
   logic             rt_last;

   logic                 sq_valid;
   logic [31:0]          sq_root;
   logic [SQ_SIDE_W-1:0] sq_side_in;
   logic [SQ_SIDE_W-1:0] sq_side;

   logic                 pa_valid_ff;
   logic [2:0][45:0]     pa_num_ff;
   logic [2:0][32:0]     pa_den_ff;
   logic [NA_SIDE_W-1:0] pa_side_ff;

   logic                 da_valid;
   logic [2:0][14:0]     da_quo;
   logic [NA_SIDE_W-1:0] da_side;

   logic                 pb_valid_ff;
   logic [1:0][30:0]     pb_num_in;
   logic [1:0][16:0]     pb_den_in;
   logic [1:0][30:0]     pb_num_ff;
   logic [1:0][16:0]     pb_den_ff;
   logic [NB_SIDE_W-1:0] pb_side_in;
   logic [NB_SIDE_W-1:0] pb_side_ff;

   logic                 db_valid;
   logic [1:0][15:0]     db_quo;
   logic [NB_SIDE_W-1:0] db_side;

   logic                    out_valid_ff;
   logic signed [REFL_W-1:0] refl_in [3];
   logic signed [REFL_W-1:0] refl_ff [3];
   logic [TEX_W-1:0]        tex_in [2];
   logic [TEX_W-1:0]        tex_ff [2];
   logic                    back_in;
   logic                    back_ff;
   logic                    last_ff;

   // The whole pipeline moves unless a finished transaction is waiting.
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_row0_ff <= ROT_ROW0_RST;
         rot_row1_ff <= ROT_ROW1_RST;
         rot_row2_ff <= ROT_ROW2_RST;
         eye_x_ff    <= '0;
         eye_y_ff    <= '0;
         eye_z_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ROT_ROW0: rot_row0_ff <= csr_wdata;
            CSR_ROT_ROW1: rot_row1_ff <= csr_wdata;
            CSR_ROT_ROW2: rot_row2_ff <= csr_wdata;
            CSR_EYE_X:    eye_x_ff    <= csr_wdata[POS_W-1:0];
            CSR_EYE_Y:    eye_y_ff    <= csr_wdata[POS_W-1:0];
            CSR_EYE_Z:    eye_z_ff    <= csr_wdata[POS_W-1:0];
            default: ;
         endcase
      end
   end

   vpet_reflect u_reflect (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .pos_z     (req_pos_z),
      .norm_x    (req_norm_x),
      .norm_y    (req_norm_y),
      .norm_z    (req_norm_z),
      .last_in   (req_last_vertex),
      .eye_x     (eye_x_ff),
      .eye_y     (eye_y_ff),
      .eye_z     (eye_z_ff),
      .out_valid (rf_valid),
      .r_out     (rf_r),
      .last_out  (rf_last)
   );

   vpet_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rf_valid),
      .r_in      (rf_r),
      .last_in   (rf_last),
      .rot_row0  (rot_row0_ff),
      .rot_row1  (rot_row1_ff),
      .rot_row2  (rot_row2_ff),
      .out_valid (rt_valid),
      .ss_out    (rt_ss),
      .wabs_out  (rt_wabs),
      .sgn_out   (rt_sgn),
      .last_out  (rt_last)
   );

   assign sq_side_in = {rt_last, rt_sgn, rt_wabs[2], rt_wabs[1], rt_wabs[0]};

   vpet_isqrt #(
      .SIDE_W (SQ_SIDE_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rt_valid),
      .radicand  (rt_ss),
      .side_in   (sq_side_in),
      .out_valid (sq_valid),
      .root      (sq_root),
      .side_out  (sq_side)
   );

   // Normalize setup: round(|w| * 16384 / len) as (|w| << 15 + len) / (2 len).
   always_ff @(posedge clock) begin
      if (reset) begin
         pa_valid_ff <= 1'b0;
      end else if (en) begin
         pa_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pa_num_ff[i] <= {sq_side[i*MAG_W +: MAG_W], 15'd0} + 46'(sq_root);
            pa_den_ff[i] <= {sq_root, 1'b0};
         end
         pa_side_ff <= {sq_side[SQ_SIDE_W-1], (sq_root == '0),
                        sq_side[3*MAG_W +: 3]};
      end
   end

   vpet_div #(
      .LANES  (3),
      .NUM_W  (46),
      .DEN_W  (33),
      .Q_W    (15),
      .SIDE_W (NA_SIDE_W)
   ) u_div_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pa_valid_ff),
      .num       (pa_num_ff),
      .den       (pa_den_ff),
      .side_in   (pa_side_ff),
      .out_valid (da_valid),
      .quo       (da_quo),
      .side_out  (da_side)
   );

   // Texture setup: round(32768 |x| / (16384 + |z|)) from the normalized components.
   always_comb begin
      logic [2:0][14:0] qm;
      logic [15:0]      base;
      for (int i = 0; i < 3; i++) begin
         qm[i] = da_side[3] ? 15'd0 : da_quo[i];
      end
      base = 16'(qm[2]) + ONE_Q14;
      for (int i = 0; i < 2; i++) begin
         pb_num_in[i] = {qm[i], 16'd0} + 31'(base);
         pb_den_in[i] = {base, 1'b0};
      end
      pb_side_in = {da_side[4], da_side[2:0], qm[2], qm[1], qm[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pb_valid_ff <= 1'b0;
      end else if (en) begin
         pb_valid_ff <= da_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pb_num_ff  <= pb_num_in;
         pb_den_ff  <= pb_den_in;
         pb_side_ff <= pb_side_in;
      end
   end

   vpet_div #(
      .LANES  (2),
      .NUM_W  (31),
      .DEN_W  (17),
      .Q_W    (16),
      .SIDE_W (NB_SIDE_W)
   ) u_div_tex (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pb_valid_ff),
      .num       (pb_num_ff),
      .den       (pb_den_ff),
      .side_in   (pb_side_ff),
      .out_valid (db_valid),
      .quo       (db_quo),
      .side_out  (db_side)
   );

   // Final signs, paraboloid side and saturated texture coordinates.
   always_comb begin
      logic [14:0] qm;
      logic        neg;
      logic [16:0] sum;
      for (int i = 0; i < 3; i++) begin
         qm         = db_side[i*15 +: 15];
         neg        = db_side[45 + i] && (qm != '0);
         refl_in[i] = neg ? -$signed(16'(qm)) : $signed(16'(qm));
      end
      back_in = db_side[47] && (db_side[30 +: 15] != '0);
      for (int i = 0; i < 2; i++) begin
         neg = db_side[45 + i] && (db_side[i*15 +: 15] != '0);
         if (neg) begin
            sum       = TEX_HALF + 17'(db_quo[i]);
            tex_in[i] = sum[16] ? '1 : sum[15:0];
         end else begin
            sum       = TEX_HALF - 17'(db_quo[i]);
            tex_in[i] = sum[15:0];
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= db_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         refl_ff <= refl_in;
         tex_ff  <= tex_in;
         back_ff <= back_in;
         last_ff <= db_side[NB_SIDE_W-1];
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_refl_x       = refl_ff[0];
   assign rsp_refl_y       = refl_ff[1];
   assign rsp_refl_z       = refl_ff[2];
   assign rsp_tex_u        = tex_ff[0];
   assign rsp_tex_v        = tex_ff[1];
   assign rsp_back_side    = back_ff;
   assign rsp_vertex_color = back_ff ? COLOR_BACK : COLOR_FRONT;
   assign rsp_last_out     = last_ff;

endmodule

// ===== test/texgen_checker.sv =====
// Checker for the paraboloid environment texgen core: predicts each result and compares it.
// Depends on vpet_pkg; watches the request, response and csr ports of the core.
module texgen_checker
   import vpet_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [POS_W-1:0]  req_pos_z,
   input  logic signed [NRM_W-1:0]  req_norm_x,
   input  logic signed [NRM_W-1:0]  req_norm_y,
   input  logic signed [NRM_W-1:0]  req_norm_z,
   input  logic                     req_last_vertex,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [REFL_W-1:0] rsp_refl_x,
   input  logic signed [REFL_W-1:0] rsp_refl_y,
   input  logic signed [REFL_W-1:0] rsp_refl_z,
   input  logic [TEX_W-1:0]         rsp_tex_u,
   input  logic [TEX_W-1:0]         rsp_tex_v,
   input  logic                     rsp_back_side,
   input  logic [COLOR_W-1:0]       rsp_vertex_color,
   input  logic                     rsp_last_out,
   input  logic                     csr_wr_en,
   input  logic [2:0]               csr_index,
   input  logic [ROW_W-1:0]         csr_wdata,
   output int                       error_count,
   output int                       pending_count
);

   typedef struct packed {
      logic [15:0] rx, ry, rz, u, v;
      logic        back;
      logic [31:0] color;
      logic        last;
   } texel_type;

   texel_type texel_queue[$];
   logic [ROW_W-1:0] matrix_row[3];
   logic signed [POS_W-1:0] eye_pos[3];

   assign pending_count = texel_queue.size();

   function automatic longint abs64(longint a);
      return a < 0 ? -a : a;
   endfunction

   // Shift all three magnitudes right together until the largest is below 2^30.
   function automatic void block_shift(ref longint vec[3]);
      longint big;
      int sh;
      big = abs64(vec[0]);
      if (abs64(vec[1]) > big) big = abs64(vec[1]);
      if (abs64(vec[2]) > big) big = abs64(vec[2]);
      sh = 0;
      while ((big >>> sh) >= (64'sd1 <<< 30)) sh++;
      for (int i = 0; i < 3; i++)
         vec[i] = vec[i] < 0 ? -(abs64(vec[i]) >>> sh) : (vec[i] >>> sh);
   endfunction

   function automatic longint int_sqrt(longint unsigned val);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > val) bitv >>= 2;
      while (bitv != 0) begin
         if (val >= root + bitv) begin
            val -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(root);
   endfunction

   function automatic logic [15:0] paraboloid_coord(longint x, longint z);
      longint den, t, u;
      den = 16384 + abs64(z);
      t = (2 * 32768 * abs64(x) + den) / (2 * den);
      u = 32768 - (x < 0 ? -t : t);
      if (u < 0) u = 0;
      if (u > 65535) u = 65535;
      return u[15:0];
   endfunction

   function automatic texel_type predict_texel(longint px, longint py, longint pz,
                                               longint nx, longint ny, longint nz,
                                               logic last);
      longint d[3], n[3], r[3], w[3], q[3];
      longint nd, nn, len;
      longint unsigned ss;
      texel_type res;
      d[0] = longint'(eye_pos[0]) - px;
      d[1] = longint'(eye_pos[1]) - py;
      d[2] = longint'(eye_pos[2]) - pz;
      n[0] = nx; n[1] = ny; n[2] = nz;
      nd = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
      nn = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
      for (int i = 0; i < 3; i++) r[i] = 2 * nd * n[i] - nn * d[i];
      block_shift(r);
      for (int i = 0; i < 3; i++) begin
         w[i] = 0;
         for (int c = 0; c < 3; c++)
            w[i] += longint'($signed(matrix_row[i][16*c +: 16])) * r[c];
      end
      block_shift(w);
      ss = 0;
      for (int i = 0; i < 3; i++) ss += abs64(w[i]) * abs64(w[i]);
      len = int_sqrt(ss);
      for (int i = 0; i < 3; i++) begin
         if (len == 0) q[i] = 0;
         else begin
            q[i] = (2 * abs64(w[i]) * 16384 + len) / (2 * len);
            if (w[i] < 0) q[i] = -q[i];
         end
      end
      res.rx = q[0][15:0];
      res.ry = q[1][15:0];
      res.rz = q[2][15:0];
      res.u = paraboloid_coord(q[0], q[2]);
      res.v = paraboloid_coord(q[1], q[2]);
      res.back = q[2] < 0;
      res.color = res.back ? COLOR_BACK : COLOR_FRONT;
      res.last = last;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Track the register file, predict on each accepted vertex, compare each result.
   always @(posedge clock) begin
      texel_type want;
      if (reset) begin
         error_count = 0;
         matrix_row[0] = ROT_ROW0_RST;
         matrix_row[1] = ROT_ROW1_RST;
         matrix_row[2] = ROT_ROW2_RST;
         for (int i = 0; i < 3; i++) eye_pos[i] = '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ROT_ROW0: matrix_row[0] = csr_wdata;
               CSR_ROT_ROW1: matrix_row[1] = csr_wdata;
               CSR_ROT_ROW2: matrix_row[2] = csr_wdata;
               CSR_EYE_X: eye_pos[0] = csr_wdata[POS_W-1:0];
               CSR_EYE_Y: eye_pos[1] = csr_wdata[POS_W-1:0];
               CSR_EYE_Z: eye_pos[2] = csr_wdata[POS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            texel_queue.push_back(predict_texel(req_pos_x, req_pos_y, req_pos_z,
               req_norm_x, req_norm_y, req_norm_z, req_last_vertex));
         if (rsp_valid && !rsp_stall) begin
            if (texel_queue.size() == 0) begin
               report_mismatch("unexpected transaction", 0, 0);
            end else begin
               want = texel_queue.pop_front();
               if (rsp_refl_x !== want.rx) report_mismatch("refl_x", rsp_refl_x, want.rx);
               if (rsp_refl_y !== want.ry) report_mismatch("refl_y", rsp_refl_y, want.ry);
               if (rsp_refl_z !== want.rz) report_mismatch("refl_z", rsp_refl_z, want.rz);
               if (rsp_tex_u !== want.u) report_mismatch("tex_u", rsp_tex_u, want.u);
               if (rsp_tex_v !== want.v) report_mismatch("tex_v", rsp_tex_v, want.v);
               if (rsp_back_side !== want.back)
                  report_mismatch("back_side", rsp_back_side, want.back);
               if (rsp_vertex_color !== want.color)
                  report_mismatch("vertex_color", rsp_vertex_color, want.color);
               if (rsp_last_out !== want.last)
                  report_mismatch("last_out", rsp_last_out, want.last);
            end
         end
      end
   end

endmodule

// ===== test/tb.sv =====
// Testbench top for the paraboloid environment texgen core: stimulus, idling and verdict.
// Depends on vpet_pkg, the core and texgen_checker.
module tb;
   import vpet_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [POS_W-1:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [NRM_W-1:0] req_norm_x = 0, req_norm_y = 0, req_norm_z = 0;
   logic req_last_vertex = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [REFL_W-1:0] rsp_refl_x, rsp_refl_y, rsp_refl_z;
   logic [TEX_W-1:0] rsp_tex_u, rsp_tex_v;
   logic rsp_back_side, rsp_last_out;
   logic [COLOR_W-1:0] rsp_vertex_color;
   logic csr_wr_en = 0;
   logic [2:0] csr_index = 0;
   logic [ROW_W-1:0] csr_wdata = 0;
   int error_count, pending_count;
   int idle_pct = 0, stall_pct = 0;
   logic hold_off = 0;

   localparam int PIPE_DEPTH = 81;

   always #4 clock = ~clock;

   vertex_paraboloid_env_texgen_core dut (.*);
   texgen_checker checker_i (.*);

   // Receiver stalls at random, or solidly during a hold-off.
   always @(posedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
   end

   task automatic write_reg(csr_index_type idx, logic [ROW_W-1:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   // Wait for the pipeline to drain before touching registers.
   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_normal();
      case ($urandom_range(9))
         0: return 16'(int'($urandom_range(32768)) - 16384);
         1: return 16'($urandom);
         2: return 16'sd16384;
         3: return -16'sd16384;
         default: return 16'(int'($urandom_range(4096)) - 2048);
      endcase
   endfunction

   function automatic logic signed [23:0] pick_pos();
      case ($urandom_range(5))
         0: return 24'($urandom);
         1: return 24'h7fffff;
         2: return 24'h800000;
         default: return 24'(int'($urandom_range(8192)) - 4096);
      endcase
   endfunction

   // Offer one vertex and hold it until the core takes it.
   task automatic send_vertex(logic signed [23:0] px, py, pz,
                              logic signed [15:0] nx, ny, nz, logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz;
      req_norm_x <= nx; req_norm_y <= ny; req_norm_z <= nz;
      req_last_vertex <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic random_vertices(int count);
      for (int i = 0; i < count; i++)
         send_vertex(pick_pos(), pick_pos(), pick_pos(),
                     pick_normal(), pick_normal(), pick_normal(), 1'($urandom));
      req_valid <= 0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed corners with reset registers.
      send_vertex(0, 0, 0, 0, 0, 0, 0);
      send_vertex(24'h7fffff, 24'h800000, 24'h7fffff, 16'sd16384, 0, 0, 1);
      send_vertex(24'h800000, 24'h7fffff, 24'h800000, -16'sd16384, -16'sd16384, -16'sd16384, 0);
      send_vertex(256, 0, 0, 0, 0, 16'sd16384, 1);
      send_vertex(0, 0, -256, 0, 0, 16'sd16384, 0);
      send_vertex(0, 0, 256, 0, 0, 16'sd16384, 0);
      send_vertex(100, -200, 300, 16'h7fff, 16'h8000, 16'hffff, 1);
      send_vertex(-512, 512, 0, 16'sd11585, 16'sd11585, 0, 0);
      send_vertex(0, 256, 0, 0, 0, 0, 1);
      req_valid <= 0;
      drain();
      // Identity matrix with a distant eye: full texture range, front and back.
      write_reg(CSR_ROT_ROW0, 48'h0000_0000_4000);
      write_reg(CSR_ROT_ROW1, 48'h0000_4000_0000);
      write_reg(CSR_ROT_ROW2, 48'h4000_0000_0000);
      write_reg(CSR_EYE_X, 48'h0);
      write_reg(CSR_EYE_Y, 48'h0);
      write_reg(CSR_EYE_Z, 48'h0000_00ff_0000);
      send_vertex(0, 0, 0, 0, 0, 16'sd16384, 0);
      send_vertex(0, 0, 0, 0, 0, -16'sd16384, 0);
      send_vertex(0, 0, 0, 16'sd16384, 0, 0, 1);
      send_vertex(0, 0, 0, 0, -16'sd16384, 0, 1);
      send_vertex(256, 0, 0, 16'sd11585, 0, 16'sd11585, 0);
      random_vertices(200);
      drain();
      // Zero matrix: every result degenerate.
      write_reg(CSR_ROT_ROW0, 48'h0);
      write_reg(CSR_ROT_ROW1, 48'h0);
      write_reg(CSR_ROT_ROW2, 48'h0);
      random_vertices(20);
      drain();
      // Extreme matrix entries and eye at the corners.
      write_reg(CSR_ROT_ROW0, 48'hffff_ffff_ffff);
      write_reg(CSR_ROT_ROW1, 48'h8000_8000_8000);
      write_reg(CSR_ROT_ROW2, 48'h7fff_7fff_7fff);
      write_reg(CSR_EYE_X, 48'h0000_007f_ffff);
      write_reg(CSR_EYE_Y, 48'h0000_0080_0000);
      write_reg(CSR_EYE_Z, 48'hffff_ff7f_ffff);
      idle_pct = 50;
      random_vertices(200);
      // Sender pauses until every result is back.
      while (pending_count != 0) @(posedge clock);
      drain();
      // Random matrix and eye through the remaining stall and idling phases.
      for (int ph = 0; ph < 3; ph++) begin
         write_reg(CSR_ROT_ROW0, 48'({$urandom, $urandom}));
         write_reg(CSR_ROT_ROW1, 48'({$urandom, $urandom}));
         write_reg(CSR_ROT_ROW2, 48'({$urandom, $urandom}));
         write_reg(CSR_EYE_X, 48'({$urandom, $urandom}));
         write_reg(CSR_EYE_Y, 48'({$urandom, $urandom}));
         write_reg(CSR_EYE_Z, 48'({$urandom, $urandom}));
         idle_pct = (ph == 0) ? 0 : ((ph == 1) ? 0 : 38);
         stall_pct = (ph == 0) ? 50 : ((ph == 1) ? 0 : 38);
         if (ph == 1) hold_off = 1;
         random_vertices(200);
         drain();
      end
      idle_pct = 0;
      stall_pct = 0;
      random_vertices(20);
      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Long receiver hold-off, counted in cycles, while the sender keeps offering.
   initial begin
      wait (hold_off);
      repeat (300) @(posedge clock);
      hold_off = 0;
   end

   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
